>>> rtl/tsw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsw_pkg
// Shared types, codes and helpers of the texture sampler with wrap modes.
// ----------------------------------------------------------------------------
package tsw_pkg;

  localparam int MAX_TEXELS_DEF = 16384;
  localparam int DIM_W          = 11;
  localparam int ADDR_W         = 14;
  localparam int COORD_W        = 24;
  localparam int CHAN_W         = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int FIFO_DEPTH     = 8;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [1:0] WRAP_REPEAT = 2'd0;
  localparam logic [1:0] WRAP_CLAMP  = 2'd1;
  localparam logic [1:0] WRAP_MIRROR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_S     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_T     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FALLBACK   = 3'd5;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              used_fallback;
  } out_item_t;

  // wrap a Q8.16 coordinate to Q1.16 in [0, 1.0]
  function automatic logic [16:0] wrap_axis(input logic [COORD_W-1:0] bits,
                                            input logic [1:0] mode);
    logic [16:0] m;
    logic [16:0] r;
    m = bits[16:0];
    unique case (mode)
      WRAP_CLAMP: begin
        if (bits[COORD_W-1]) r = 17'd0;
        else if (bits > {7'd0, ONE_Q16}) r = ONE_Q16;
        else r = bits[16:0];
      end
      WRAP_MIRROR: begin
        if (m <= ONE_Q16) r = m;
        else r = 17'h1ffff - m + 17'd1;
      end
      default: r = {1'b0, bits[15:0]};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/tsw_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsw_in_if
// Input channel: texel writes and sample requests.
// ----------------------------------------------------------------------------
interface tsw_in_if;
  logic                            valid;
  logic                            ready;
  logic                            command;
  logic [tsw_pkg::ADDR_W-1:0]      texel_addr;
  logic [31:0]                     texel_rgba;
  logic signed [tsw_pkg::COORD_W-1:0] coord_u;
  logic signed [tsw_pkg::COORD_W-1:0] coord_v;

  modport source (output valid, command, texel_addr, texel_rgba, coord_u, coord_v,
                  input ready);
  modport sink (input valid, command, texel_addr, texel_rgba, coord_u, coord_v,
                output ready);
endinterface
`default_nettype wire

>>> rtl/tsw_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsw_out_if
// Result channel: filtered color in Q8.8 per channel.
// ----------------------------------------------------------------------------
interface tsw_out_if;
  logic                        valid;
  logic                        ready;
  logic [tsw_pkg::CHAN_W-1:0]  red;
  logic [tsw_pkg::CHAN_W-1:0]  green;
  logic [tsw_pkg::CHAN_W-1:0]  blue;
  logic [tsw_pkg::CHAN_W-1:0]  alpha;
  logic                        used_fallback;

  modport source (output valid, red, green, blue, alpha, used_fallback, input ready);
  modport sink (input valid, red, green, blue, alpha, used_fallback, output ready);
endinterface
`default_nettype wire

>>> rtl/tsw_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsw_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tsw_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tsw_pkg::CFG_IDX_W-1:0]  index;
  logic [31:0]                    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/texture_sampler_wrap_bilinear_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// texture_sampler_wrap_bilinear_unit
// Texel store with wrap, nearest and bilinear sampling of RGBA8 texels.
// ----------------------------------------------------------------------------
// a write commits from the issue stage; a sample result passes the memory read,
// the horizontal blend and the result queue. Throughput: writes one per cycle,
// nearest samples one per cycle while a result queue reservation is free; a
// bilinear sample issues its texel reads in turn on the single read/write port
// reset: control and config registers take their reset values, the texel
// memory is not cleared and holds no defined contents until written
`default_nettype none
module texture_sampler_wrap_bilinear_unit #(
  parameter int MAX_TEXELS = tsw_pkg::MAX_TEXELS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tsw_in_if.sink      in_ch,
  tsw_out_if.source   out_ch,
  tsw_cfg_if.sink     cfg_ch
);

  localparam int IDXW = $clog2(MAX_TEXELS);
  localparam int EW   = IDXW + 1;
  localparam int DW   = tsw_pkg::DIM_W;
  localparam int PW   = $clog2(tsw_pkg::FIFO_DEPTH);
  localparam int CW   = PW + 1;

  // configuration
  logic [DW-1:0]   w_r, h_r;
  logic [1:0]      wm_s_r, wm_t_r;
  logic            bil_r;
  logic [31:0]     fb_rgba_r;
  logic [2*DW-1:0] wh_r;
  logic [DW-1:0]   wm1, hm1;

  assign cfg_ch.ready = 1'b1;
  assign wm1 = w_r - DW'(1);
  assign hm1 = h_r - DW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r       <= '0;
      h_r       <= '0;
      wm_s_r    <= tsw_pkg::WRAP_REPEAT;
      wm_t_r    <= tsw_pkg::WRAP_REPEAT;
      bil_r     <= 1'b1;
      fb_rgba_r <= 32'hffff_ffff;
      wh_r      <= '0;
    end else begin
      wh_r <= w_r * h_r;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          tsw_pkg::REG_TEX_WIDTH:  w_r <= cfg_ch.data[DW-1:0];
          tsw_pkg::REG_TEX_HEIGHT: h_r <= cfg_ch.data[DW-1:0];
          tsw_pkg::REG_WRAP_S:     wm_s_r <= cfg_ch.data[1:0];
          tsw_pkg::REG_WRAP_T:     wm_t_r <= cfg_ch.data[1:0];
          tsw_pkg::REG_FILTER:     bil_r <= cfg_ch.data[0];
          tsw_pkg::REG_FALLBACK:   fb_rgba_r <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  // pipeline valids and handshakes
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic adv2, adv3, adv4, s4_done, in_fire;

  // stage 1: input register
  logic                        s1_cmd_r;
  logic [tsw_pkg::ADDR_W-1:0]  s1_addr_r;
  logic [31:0]                 s1_data_r;
  logic [tsw_pkg::COORD_W-1:0] s1_u_r, s1_cv_r;

  // stage 2: scaled coordinates
  logic                        s2_cmd_r;
  logic [tsw_pkg::ADDR_W-1:0]  s2_addr_r;
  logic [31:0]                 s2_data_r;
  logic [27:0]                 s2_px_r, s2_py_r;

  // stage 3: texel coordinates and weights
  logic                        s3_cmd_r;
  logic [tsw_pkg::ADDR_W-1:0]  s3_addr_r;
  logic [31:0]                 s3_data_r;
  logic [DW-1:0]               s3_x0_r, s3_x1_r, s3_y0_r, s3_y1_r;
  logic [15:0]                 s3_tx_r, s3_ty_r;

  // stage 4: memory issue
  logic                        s4_cmd_r;
  logic [tsw_pkg::ADDR_W-1:0]  s4_addr_r;
  logic [31:0]                 s4_data_r;
  logic [DW-1:0]               s4_x0_r, s4_x1_r;
  logic [2*DW-1:0]             s4_row0_r, s4_row1_r;
  logic [15:0]                 s4_tx_r, s4_ty_r;
  logic [1:0]                  k_r;

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign adv4        = s3_v_r && (!s4_v_r || s4_done);
  assign adv3        = s2_v_r && (!s3_v_r || adv4);
  assign adv2        = s1_v_r && (!s2_v_r || adv3);
  assign in_ch.ready = !s1_v_r || adv2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (in_fire) s1_v_r <= 1'b1;
      else if (adv2) s1_v_r <= 1'b0;
      if (adv2) s2_v_r <= 1'b1;
      else if (adv3) s2_v_r <= 1'b0;
      if (adv3) s3_v_r <= 1'b1;
      else if (adv4) s3_v_r <= 1'b0;
      if (adv4) s4_v_r <= 1'b1;
      else if (s4_done) s4_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r  <= in_ch.command;
      s1_addr_r <= in_ch.texel_addr;
      s1_data_r <= in_ch.texel_rgba;
      s1_u_r    <= in_ch.coord_u;
      s1_cv_r   <= in_ch.coord_v;
    end
  end

  // wrap and scale, one multiplier per axis
  logic [16:0]   u_wr, vf;
  logic [DW-1:0] fac_x, fac_y;

  always_comb begin
    u_wr  = tsw_pkg::wrap_axis(s1_u_r, wm_s_r);
    vf    = tsw_pkg::ONE_Q16 - tsw_pkg::wrap_axis(s1_cv_r, wm_t_r);
    fac_x = bil_r ? wm1 : w_r;
    fac_y = bil_r ? hm1 : h_r;
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_cmd_r  <= s1_cmd_r;
      s2_addr_r <= s1_addr_r;
      s2_data_r <= s1_data_r;
      s2_px_r   <= u_wr * fac_x;
      s2_py_r   <= vf * fac_y;
    end
  end

  // integer part clamped to the last texel, neighbor clamped likewise
  logic [DW:0]   xi, yi;
  logic [DW-1:0] x0, y0;
  logic [DW:0]   x0p, y0p;

  always_comb begin
    xi  = s2_px_r[16+DW:16];
    yi  = s2_py_r[16+DW:16];
    x0  = (xi > {1'b0, wm1}) ? wm1 : xi[DW-1:0];
    y0  = (yi > {1'b0, hm1}) ? hm1 : yi[DW-1:0];
    x0p = {1'b0, x0} + (DW+1)'(1);
    y0p = {1'b0, y0} + (DW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_cmd_r  <= s2_cmd_r;
      s3_addr_r <= s2_addr_r;
      s3_data_r <= s2_data_r;
      s3_x0_r   <= x0;
      s3_y0_r   <= y0;
      s3_x1_r   <= (x0p > {1'b0, wm1}) ? wm1 : x0p[DW-1:0];
      s3_y1_r   <= (y0p > {1'b0, hm1}) ? hm1 : y0p[DW-1:0];
      s3_tx_r   <= bil_r ? s2_px_r[15:0] : 16'd0;
      s3_ty_r   <= bil_r ? s2_py_r[15:0] : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      s4_cmd_r  <= s3_cmd_r;
      s4_addr_r <= s3_addr_r;
      s4_data_r <= s3_data_r;
      s4_x0_r   <= s3_x0_r;
      s4_x1_r   <= s3_x1_r;
      s4_row0_r <= s3_y0_r * w_r;
      s4_row1_r <= s3_y1_r * w_r;
      s4_tx_r   <= s3_tx_r;
      s4_ty_r   <= s3_ty_r;
    end
  end

  // issue stage: writes commit here in order, so the extent check sees them
  logic [EW-1:0]   extent_r;
  logic [CW-1:0]   resv_r, fifo_cnt_r;
  logic            credit_ok, fb_all, is_sample, step, last_step, wr_en, out_fire;
  logic [31:0]     rd_sum, wr_addr32;
  logic [IDXW-1:0] mem_addr;

  always_comb begin
    is_sample = s4_cmd_r == tsw_pkg::CMD_SAMPLE;
    credit_ok = resv_r < CW'(tsw_pkg::FIFO_DEPTH);
    fb_all    = (w_r == '0) || (h_r == '0) || (32'(wh_r) > 32'(extent_r));
    last_step = fb_all || !bil_r || (k_r == 2'd3);
    step      = s4_v_r && is_sample && credit_ok;
    wr_addr32 = 32'(s4_addr_r);
    wr_en     = s4_v_r && !is_sample && (wr_addr32 < 32'(MAX_TEXELS));
    s4_done   = s4_v_r && (!is_sample || (credit_ok && last_step));
    unique case (k_r)
      2'd0: rd_sum = 32'(s4_row0_r) + 32'(s4_x0_r);
      2'd1: rd_sum = 32'(s4_row0_r) + 32'(s4_x1_r);
      2'd2: rd_sum = 32'(s4_row1_r) + 32'(s4_x0_r);
      default: rd_sum = 32'(s4_row1_r) + 32'(s4_x1_r);
    endcase
    mem_addr = wr_en ? wr_addr32[IDXW-1:0] : rd_sum[IDXW-1:0];
  end

  logic [31:0] tex_mem [MAX_TEXELS];
  logic [31:0] rd_r;

  always_ff @(posedge clk) begin
    if (wr_en) tex_mem[mem_addr] <= s4_data_r;
    else if (step && !fb_all) rd_r <= tex_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      extent_r <= '0;
      k_r      <= '0;
    end else begin
      if (wr_en && (wr_addr32 + 32'd1 > 32'(extent_r)))
        extent_r <= EW'(wr_addr32 + 32'd1);
      if (step) k_r <= last_step ? 2'd0 : k_r + 2'd1;
    end
  end

  // read tags ride alongside the memory read
  logic        tg_v_r, tg_last_r, tg_fb_r, tg_near_r;
  logic [1:0]  tg_k_r;
  logic [15:0] tg_tx_r, tg_ty_r;
  logic [31:0] tex_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) tg_v_r <= 1'b0;
    else tg_v_r <= step;
    if (step) begin
      tg_k_r    <= k_r;
      tg_last_r <= last_step;
      tg_fb_r   <= fb_all;
      tg_near_r <= !bil_r;
      tg_tx_r   <= s4_tx_r;
      tg_ty_r   <= s4_ty_r;
    end
    if (tg_v_r && tg_k_r != 2'd3) tex_r[tg_k_r] <= rd_r;
  end

  // horizontal blend
  logic        d_v_r, d_fb_r;
  logic [15:0] d_ty_r;
  logic [23:0] d_r0_r [4];
  logic [23:0] d_r1_r [4];
  logic [31:0] c00, c10, c01, c11;
  logic [16:0] wx0;
  logic        d_load;

  // nearest uses one texel in c00 and c11, c10 and c01 are held at zero
  always_comb begin
    d_load = tg_v_r && tg_last_r;
    c00    = tg_near_r ? rd_r : tex_r[0];
    c10    = tg_near_r ? 32'd0 : tex_r[1];
    c01    = tg_near_r ? 32'd0 : tex_r[2];
    c11    = rd_r;
    wx0    = tsw_pkg::ONE_Q16 - {1'b0, tg_tx_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) d_v_r <= 1'b0;
    else d_v_r <= d_load;
    if (d_load) begin
      d_fb_r <= tg_fb_r;
      d_ty_r <= tg_ty_r;
      for (int c = 0; c < 4; c++) begin
        d_r0_r[c] <= 24'(c00[8*c +: 8] * wx0 + c10[8*c +: 8] * tg_tx_r);
        d_r1_r[c] <= 24'(c01[8*c +: 8] * wx0 + c11[8*c +: 8] * tg_tx_r);
      end
    end
  end

  // vertical blend with round half up, straight into the result queue
  logic [16:0]        wy0;
  logic [40:0]        acc [4];
  logic [15:0]        ch  [4];
  tsw_pkg::out_item_t push_item;

  always_comb begin
    wy0 = tsw_pkg::ONE_Q16 - {1'b0, d_ty_r};
    for (int c = 0; c < 4; c++) begin
      acc[c] = 41'(d_r0_r[c] * wy0) + 41'(d_r1_r[c] * d_ty_r) + 41'h80_0000;
      ch[c]  = d_fb_r ? {fb_rgba_r[8*c +: 8], 8'h00} : acc[c][39:24];
    end
    push_item.red           = ch[0];
    push_item.green         = ch[1];
    push_item.blue          = ch[2];
    push_item.alpha         = ch[3];
    push_item.used_fallback = d_fb_r;
  end

  // result queue; reservations cover queued and in-flight samples
  tsw_pkg::out_item_t fifo_r [tsw_pkg::FIFO_DEPTH];
  logic [PW-1:0]      wr_ptr_r, rd_ptr_r;
  tsw_pkg::out_item_t head;

  assign out_fire = out_ch.valid && out_ch.ready;
  assign head     = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (d_v_r) fifo_r[wr_ptr_r] <= push_item;
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
      resv_r     <= '0;
    end else begin
      if (d_v_r) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (out_fire) rd_ptr_r <= rd_ptr_r + PW'(1);
      fifo_cnt_r <= fifo_cnt_r + CW'(d_v_r) - CW'(out_fire);
      resv_r     <= resv_r + CW'(s4_done && is_sample) - CW'(out_fire);
    end
  end

  assign out_ch.valid         = fifo_cnt_r != '0;
  assign out_ch.red           = head.red;
  assign out_ch.green         = head.green;
  assign out_ch.blue          = head.blue;
  assign out_ch.alpha         = head.alpha;
  assign out_ch.used_fallback = head.used_fallback;

  a_cnt_in_resv: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= resv_r) else $error("queued results exceed reservations");

  a_resv_bound: assert property (@(posedge clk) disable iff (!rst_n)
    resv_r <= CW'(tsw_pkg::FIFO_DEPTH)) else $error("reservations exceed queue depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    d_v_r |-> fifo_cnt_r < CW'(tsw_pkg::FIFO_DEPTH)) else $error("result queue overflow");

  a_extent_grows: assert property (@(posedge clk) disable iff (!rst_n)
    extent_r >= $past(extent_r)) else $error("loaded extent shrank");

endmodule
`default_nettype wire
